// ===== design/min_max_contrast_stretch_assert.svh =====
// Assertion macros used by the contrast stretch controller.
`ifndef MIN_MAX_CONTRAST_STRETCH_ASSERT_SVH
`define MIN_MAX_CONTRAST_STRETCH_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define MMCS_ASSERT_SAME(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("mmcs assertion failed");

// Check that a condition implies another in the following cycle.
`define MMCS_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("mmcs assertion failed");

`endif

// ===== design/mmcs_pkg.sv =====
package mmcs_pkg;

    localparam int PIXEL_BITS = 8;
    localparam int CNT_BITS   = (PIXEL_BITS > 1) ? $clog2(PIXEL_BITS) : 1;
    localparam int IDX_BITS   = 2;

    localparam logic [CNT_BITS-1:0] CNT_START = CNT_BITS'(PIXEL_BITS - 1);

    typedef enum logic [IDX_BITS-1:0] {
        REG_OUT_LOW  = 2'd0,
        REG_OUT_HIGH = 2'd1
    } reg_index_t;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel_in;
        logic                  last_in;
    } in_item_t;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel_out;
        logic                  last_out;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_MEASURE,
        ST_MAP,
        ST_DIV,
        ST_WB
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic measure;
        logic load;
        logic step;
        logic write;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic in_last;
        logic out_free;
        logic last;
    } status_t;

endpackage

// ===== design/mmcs_datapath.sv =====
module mmcs_datapath
    import mmcs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  in_item_t              in_data,
    output out_item_t             out_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    input  logic                  cfg_write,
    input  logic [IDX_BITS-1:0]   cfg_index,
    input  logic [PIXEL_BITS-1:0] cfg_data,
    input  cmd_t                  cmd,
    output status_t               status
);

    logic [PIXEL_BITS-1:0]   out_low_reg;
    logic [PIXEL_BITS-1:0]   out_high_reg;
    logic [PIXEL_BITS-1:0]   min_reg;
    logic [PIXEL_BITS-1:0]   max_reg;
    logic                    last_reg;
    logic                    dpos_reg;
    logic                    dneg_reg;
    logic                    dge_reg;
    logic [PIXEL_BITS-1:0]   rem_reg;
    logic [PIXEL_BITS-1:0]   rem_next;
    logic [PIXEL_BITS-1:0]   quo_reg;
    logic [PIXEL_BITS-1:0]   quo_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    out_item_t               out_data_reg;

    logic [PIXEL_BITS-1:0]   diff;
    logic [PIXEL_BITS-1:0]   range;
    logic [2*PIXEL_BITS-1:0] prod;
    logic [PIXEL_BITS-1:0]   span;
    logic [PIXEL_BITS:0]     rem_ext;
    logic [PIXEL_BITS:0]     rem_sub;
    logic                    ge;
    logic [PIXEL_BITS:0]     quo_shift;
    logic [PIXEL_BITS-1:0]   result;
    logic                    out_free;

    assign diff  = in_data.pixel_in - min_reg;
    assign range = out_high_reg - out_low_reg;
    assign prod  = {{PIXEL_BITS{1'b0}}, diff} * {{PIXEL_BITS{1'b0}}, range};
    assign span  = max_reg - min_reg;

    // one restoring step: bring in the next numerator bit, subtract if it fits
    assign rem_ext   = {rem_reg, quo_reg[PIXEL_BITS-1]};
    assign rem_sub   = rem_ext - {1'b0, span};
    assign ge        = (rem_ext >= {1'b0, span});
    assign rem_next  = ge ? rem_sub[PIXEL_BITS-1:0] : rem_ext[PIXEL_BITS-1:0];
    assign quo_shift = {quo_reg, ge};
    assign quo_next  = quo_shift[PIXEL_BITS-1:0];

    always_comb
    begin
        if (min_reg >= max_reg)
        begin
            result = out_low_reg;
        end
        else if (out_high_reg < out_low_reg)
        begin
            result = dpos_reg ? out_low_reg : out_high_reg;
        end
        else if (dneg_reg)
        begin
            result = out_low_reg;
        end
        else if (dge_reg)
        begin
            result = out_high_reg;
        end
        else
        begin
            result = out_low_reg + quo_reg;
        end
    end

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.write)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_low_reg   <= '0;
            out_high_reg  <= '1;
            min_reg       <= '1;
            max_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_write && cfg_index == REG_OUT_LOW)
            begin
                out_low_reg <= cfg_data;
            end
            if (cfg_write && cfg_index == REG_OUT_HIGH)
            begin
                out_high_reg <= cfg_data;
            end
            if (cmd.measure)
            begin
                if (in_data.pixel_in < min_reg)
                begin
                    min_reg <= in_data.pixel_in;
                end
                if (in_data.pixel_in > max_reg)
                begin
                    max_reg <= in_data.pixel_in;
                end
            end
            else if (cmd.write && last_reg)
            begin
                min_reg <= '1;
                max_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            last_reg <= in_data.last_in;
            dpos_reg <= (in_data.pixel_in > min_reg);
            dneg_reg <= (in_data.pixel_in < min_reg);
            dge_reg  <= (in_data.pixel_in >= max_reg);
            rem_reg  <= prod[2*PIXEL_BITS-1:PIXEL_BITS];
            quo_reg  <= prod[PIXEL_BITS-1:0];
        end
        else if (cmd.step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
        if (cmd.write)
        begin
            out_data_reg.pixel_out <= result;
            out_data_reg.last_out  <= last_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;
    assign status.in_last  = in_data.last_in;
    assign status.out_free = out_free;
    assign status.last     = last_reg;

endmodule

// ===== design/mmcs_ctrl.sv =====
module mmcs_ctrl
    import mmcs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  status_t status,
    output cmd_t    cmd
);

    state_t              state_reg;
    state_t              state_next;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [CNT_BITS-1:0] cnt_next;
    logic                in_accept;

    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_MEASURE:
            begin
                if (in_valid && status.in_last)
                begin
                    state_next = ST_MAP;
                end
            end
            ST_MAP:
            begin
                if (in_valid)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_WB;
                end
            end
            ST_WB:
            begin
                if (status.out_free)
                begin
                    state_next = status.last ? ST_MEASURE : ST_MAP;
                end
            end
            default:
            begin
                state_next = ST_MEASURE;
            end
        endcase
    end

    always_comb
    begin
        in_stall    = 1'b1;
        cmd.measure = 1'b0;
        cmd.load    = 1'b0;
        cmd.step    = 1'b0;
        cmd.write   = 1'b0;
        case (state_reg)
            ST_MEASURE:
            begin
                in_stall    = 1'b0;
                cmd.measure = in_valid;
            end
            ST_MAP:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            ST_DIV:
            begin
                cmd.step = 1'b1;
            end
            ST_WB:
            begin
                cmd.write = status.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.load)
        begin
            cnt_next = CNT_START;
        end
        else if (cmd.step)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_MEASURE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

`include "min_max_contrast_stretch_assert.svh"

    `MMCS_ASSERT_NEXT(a_load_starts_div, clk, rst_n, cmd.load, state_reg == ST_DIV && cnt_reg == CNT_START)
    `MMCS_ASSERT_NEXT(a_div_ends_in_wb, clk, rst_n, state_reg == ST_DIV && cnt_reg == '0, state_reg == ST_WB)
    `MMCS_ASSERT_NEXT(a_last_ends_image, clk, rst_n, cmd.write && status.last, state_reg == ST_MEASURE)
    `MMCS_ASSERT_SAME(a_no_accept_busy, clk, rst_n, in_accept, state_reg == ST_MEASURE || state_reg == ST_MAP)

endmodule

// ===== design/min_max_contrast_stretch.sv =====
// Two-pass min-max contrast stretch with no frame store. Send the image once
// (measuring pass): each pixel is taken without a stall, updates the running
// minimum and maximum and gives no result item. The item flagged last_in ends
// that pass. Send the same image again (mapping pass): each pixel yields one
// item out_low + floor((v-min)*(out_high-out_low)/(max-min)), limited to the
// output range; a flat image gives out_low everywhere, and with out_high below
// out_low a pixel above the measured minimum gives out_low and any other pixel
// gives out_high. Each mapping-pass pixel is taken and its product formed, then
// the restoring divider yields one quotient bit per cycle, PIXEL_BITS bits in
// all, and the result is then written to the output register once that register
// is free; no new pixel is taken in the meantime. After the last mapped pixel
// the block clears its minimum and maximum and measures again. Write out_low
// (index 0) and out_high (index 1) only while the block is idle; other indexes
// are ignored.
module min_max_contrast_stretch
    import mmcs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input items
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_data,
    // result items
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data,
    // register writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [IDX_BITS-1:0]   cfg_index,
    input  logic [PIXEL_BITS-1:0] cfg_data
);

    cmd_t    cmd;
    status_t status;

    // register writes are always taken
    assign cfg_ready = 1'b1;

    mmcs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    mmcs_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
